/* rtl/arm64_address_xref_scanner_macros.svh */
// Assertion macros for the checker file of the address xref scanner.
`ifndef ARM64_ADDRESS_XREF_SCANNER_MACROS_SVH
`define ARM64_ADDRESS_XREF_SCANNER_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define AXS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("axs assertion failed");

// Clocked assertion that is also checked during reset.
`define AXS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("axs assertion failed");

`endif

/* rtl/axs_pkg.sv */
// Shared types and constants of the address xref scanner.
`timescale 1ns / 1ps
`default_nettype none
package axs_pkg;

    localparam int NUM_REGS    = 32;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int VALUE_W     = 64;
    localparam int INSTR_W     = 32;
    localparam int OFFSET_W    = 32;
    localparam int QUEUE_DEPTH = 2;

    // Opcode match masks and patterns
    localparam logic [31:0] ADRP_MASK = 32'h9F00_0000;
    localparam logic [31:0] ADRP_PAT  = 32'h9000_0000;
    localparam logic [31:0] ADD_MASK  = 32'hFF00_0000;
    localparam logic [31:0] ADD_PAT   = 32'h9100_0000;
    localparam logic [31:0] LDR_MASK  = 32'hF9C0_0000;
    localparam logic [31:0] LDR_PAT   = 32'hF940_0000;
    localparam logic [31:0] ADR_MASK  = 32'h9F00_0000;
    localparam logic [31:0] ADR_PAT   = 32'h1000_0000;
    localparam logic [31:0] LIT_MASK  = 32'hFF00_0000;
    localparam logic [31:0] LIT_PAT   = 32'h5800_0000;

    // ADD shift field codes
    localparam logic [1:0] ADD_SH_NONE = 2'd0;
    localparam logic [1:0] ADD_SH_12   = 2'd1;

    // Work class handed from decode to execute
    typedef enum logic [2:0] {
        OP_ABS_NOCMP,   // write precomputed value, no compare (ADRP)
        OP_ABS,         // write precomputed value, then compare
        OP_REL,         // write table[n] + immediate, then compare
        OP_SKIP,        // no write, no compare
        OP_PLAIN        // no write, compare table[d]
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [REG_IDX_W-1:0]   dst;
        logic [REG_IDX_W-1:0]   raddr;
        logic [VALUE_W-1:0]     value;
        logic [OFFSET_W-1:0]    pc;
        logic                   last;
    } q_entry_t;

endpackage
`default_nettype wire

/* rtl/axs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module axs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/axs_front.sv */
// Decode stage: classifies an instruction word and precomputes its operand.
`timescale 1ns / 1ps
`default_nettype none
module axs_front (
    input  wire logic [31:0]      instr,
    input  wire logic [31:0]      offset,
    input  wire logic             last,
    output axs_pkg::q_entry_t     entry
);
    import axs_pkg::*;

    logic [OFFSET_W-1:0] pc;
    logic [VALUE_W-1:0]  pc64;
    logic [VALUE_W-1:0]  sext21;
    logic [VALUE_W-1:0]  imm12;
    logic [1:0]          add_sh;

    assign pc     = {offset[OFFSET_W-1:2], 2'b00};
    assign pc64   = {{(VALUE_W-OFFSET_W){1'b0}}, pc};
    assign sext21 = {{(VALUE_W-21){instr[23]}}, instr[23:5], instr[30:29]};
    assign imm12  = {{(VALUE_W-12){1'b0}}, instr[21:10]};
    assign add_sh = instr[23:22];

    // Classify in the same priority order as the opcode groups overlap
    always_comb begin
        entry.dst   = instr[4:0];
        entry.raddr = instr[4:0];
        entry.pc    = pc;
        entry.last  = last;
        entry.kind  = OP_PLAIN;
        entry.value = '0;
        if ((instr & ADRP_MASK) == ADRP_PAT) begin
            entry.kind  = OP_ABS_NOCMP;
            entry.value = {pc64[VALUE_W-1:12], 12'h000} + {sext21[VALUE_W-13:0], 12'h000};
        end else if ((instr & ADD_MASK) == ADD_PAT) begin
            entry.raddr = instr[9:5];
            if (add_sh == ADD_SH_NONE) begin
                entry.kind  = OP_REL;
                entry.value = imm12;
            end else if (add_sh == ADD_SH_12) begin
                entry.kind  = OP_REL;
                entry.value = {imm12[VALUE_W-13:0], 12'h000};
            end else begin
                entry.kind  = OP_SKIP;
            end
        end else if ((instr & LDR_MASK) == LDR_PAT) begin
            entry.raddr = instr[9:5];
            entry.value = {imm12[VALUE_W-4:0], 3'b000};
            entry.kind  = (instr[21:10] == 12'h000) ? OP_SKIP : OP_REL;
        end else if ((instr & ADR_MASK) == ADR_PAT) begin
            entry.kind  = OP_ABS;
            entry.value = pc64 + sext21;
        end else if ((instr & LIT_MASK) == LIT_PAT) begin
            entry.kind  = OP_ABS;
            entry.value = pc64 + {{(VALUE_W-21){1'b0}}, instr[23:5], 2'b00};
        end
    end

endmodule
`default_nettype wire

/* rtl/axs_queue.sv */
// Small flop-based queue between decode and execute.
`timescale 1ns / 1ps
`default_nettype none
module axs_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  axs_pkg::q_entry_t      push_entry,
    output logic                   not_full,
    input  wire logic              pop,
    output logic                   head_valid,
    output axs_pkg::q_entry_t      head_entry
);
    import axs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign not_full   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

/* rtl/axs_back.sv */
// Execute stage: register table, update, target compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module axs_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  axs_pkg::q_entry_t      head_entry,
    output logic                   pop,
    input  wire logic [63:0]       target_address,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tuser
);
    import axs_pkg::*;

    q_entry_t               x_entry_reg;
    logic                   x_valid_reg, x_valid_next;
    logic [NUM_REGS-1:0]    valid_reg, valid_next;
    logic                   scan_done_reg, scan_done_next;
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [REG_IDX_W-1:0]   fwd_addr_reg;
    logic [VALUE_W-1:0]     fwd_data_reg;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg;
    logic [OFFSET_W-1:0]    m_offset_reg;

    logic [VALUE_W-1:0]     rdata;
    logic [VALUE_W-1:0]     base;
    logic [VALUE_W-1:0]     new_value;
    logic [VALUE_W-1:0]     cmp_value;
    logic                   wr_en;
    logic                   cmp_en;
    logic                   match;
    logic                   x_res;
    logic                   out_free;
    logic                   fire;

    // Table storage, read when an entry leaves the queue
    axs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_REGS)
    ) u_table (
        .aclk  (aclk),
        .we    (fire && wr_en),
        .waddr (x_entry_reg.dst),
        .wdata (new_value),
        .re    (pop),
        .raddr (head_entry.raddr),
        .rdata (rdata)
    );

    // Operand: forwarded last write, else table entry, else cleared zero
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == x_entry_reg.raddr)) begin
            base = fwd_data_reg;
        end else if (valid_reg[x_entry_reg.raddr]) begin
            base = rdata;
        end else begin
            base = '0;
        end
    end

    // Work of one item
    always_comb begin
        wr_en     = 1'b0;
        cmp_en    = 1'b0;
        new_value = x_entry_reg.value;
        cmp_value = x_entry_reg.value;
        case (x_entry_reg.kind)
            OP_ABS_NOCMP: begin
                wr_en = 1'b1;
            end
            OP_ABS: begin
                wr_en  = 1'b1;
                cmp_en = 1'b1;
            end
            OP_REL: begin
                wr_en     = 1'b1;
                cmp_en    = 1'b1;
                new_value = base + x_entry_reg.value;
                cmp_value = new_value;
            end
            OP_PLAIN: begin
                cmp_en    = 1'b1;
                cmp_value = base;
            end
            default: begin
                wr_en  = 1'b0;
                cmp_en = 1'b0;
            end
        endcase
        if (scan_done_reg) begin
            wr_en  = 1'b0;
            cmp_en = 1'b0;
        end
    end

    assign match    = cmp_en && (cmp_value == target_address);
    assign x_res    = !scan_done_reg && (match || x_entry_reg.last);
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = x_valid_reg && (!x_res || out_free);
    assign pop      = head_valid && (!x_valid_reg || fire);

    // Next state of control registers
    always_comb begin
        x_valid_next   = x_valid_reg;
        valid_next     = valid_reg;
        scan_done_next = scan_done_reg;
        fwd_valid_next = fwd_valid_reg;
        m_valid_next   = m_valid_reg;
        if (fire) begin
            x_valid_next = 1'b0;
            if (x_entry_reg.last) begin
                valid_next     = '0;
                scan_done_next = 1'b0;
                fwd_valid_next = 1'b0;
            end else begin
                scan_done_next = scan_done_reg || match;
                fwd_valid_next = wr_en;
                if (wr_en) begin
                    valid_next[x_entry_reg.dst] = 1'b1;
                end
            end
        end
        if (pop) begin
            x_valid_next = 1'b1;
        end
        if (fire && x_res) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg   <= 1'b0;
            valid_reg     <= '0;
            scan_done_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            x_valid_reg   <= x_valid_next;
            valid_reg     <= valid_next;
            scan_done_reg <= scan_done_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            x_entry_reg <= head_entry;
        end
        if (fire) begin
            fwd_addr_reg <= x_entry_reg.dst;
            fwd_data_reg <= new_value;
        end
        if (fire && x_res) begin
            m_found_reg  <= match;
            m_offset_reg <= match ? x_entry_reg.pc : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_offset_reg;
    assign m_tuser  = m_found_reg;

endmodule
`default_nettype wire

/* rtl/arm64_address_xref_scanner.sv */
// Top level of the AArch64 address xref scanner.
//
//  channel  dir  handshake               payload
//  s_       in   s_tvalid / s_tready     tdata = {offset, instr}, tlast = last
//  m_       out  m_tvalid / m_tready     tdata = match_offset, tuser = found
//  cfg_     in   cfg_valid / cfg_ready   cfg_data = target_address
//
// One instruction per cycle sustained while no result stalls on the m_ side;
// a word is decoded into the queue, read from the table, then executed into m_.
// The rate is set by the execute loop: table read, add, compare and write back
// keep pace with a one-entry forward of the last write.
// Reset (aresetn low, synchronous) empties the queue and clears the table valid
// bits and the target; the table needs no initialisation after reset.
// A stalled m_ side backs up the queue; s_tready drops when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module arm64_address_xref_scanner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] instr, [63:32] offset
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] match_offset
    output logic             m_tuser,   // [0] found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data
);
    import axs_pkg::*;

    q_entry_t           dec_entry;
    q_entry_t           head_entry;
    logic               head_valid;
    logic               pop;
    logic               q_not_full;
    logic [VALUE_W-1:0] target_reg;

    // Target register, written on a config transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            target_reg <= cfg_data;
        end
    end

    assign s_tready = q_not_full;

    axs_front u_front (
        .instr  (s_tdata[31:0]),
        .offset (s_tdata[63:32]),
        .last   (s_tlast),
        .entry  (dec_entry)
    );

    axs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid && s_tready),
        .push_entry (dec_entry),
        .not_full   (q_not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    axs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .target_address (target_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule
`default_nettype wire

/* rtl/axs_checker.sv */
// Port-level checker for the address xref scanner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "arm64_address_xref_scanner_macros.svh"
module axs_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser
);

    // A not-found result carries a zero offset
    `AXS_ASSERT(a_notfound_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))

    // A found offset is word aligned
    `AXS_ASSERT(a_found_aligned, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata[1:0] == 2'b00))

    // Reset leaves no result pending and the input side open
    `AXS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_tvalid && s_tready))

    // A stalled result holds until the transfer
    `AXS_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind arm64_address_xref_scanner axs_checker u_axs_checker (.*);
`default_nettype wire
